### src/rarr_pkg.sv
`default_nettype none
package rarr_pkg;

    // Storage geometry and field widths.
    localparam int POSITIONS = 64;
    localparam int POS_W     = 6;
    localparam int END_W     = 7;
    localparam int CNT_W     = $clog2(POSITIONS + 1);
    localparam int COLOR_W   = 32;
    localparam int LEN_W     = 7;

    // Length in force after reset.
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(POSITIONS);

    // Control states of the scan sequencer.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_BAD
    } state_t;

    typedef logic [COLOR_W-1:0] color_t;

endpackage
`default_nettype wire

### src/range_assign_run_report_top.sv
// Range colour assign with run report.
// A request (req_valid/req_ready) carries range_start, range_end and new_color.
// Every accepted request yields one or more results on res_valid/res_ready:
// each maximal run of equal old colours inside [range_start, range_end),
// in ascending order, the final one flagged by last_run. An empty range, or
// one that passes the used length, gives a single result with bad_range set
// and leaves the store untouched.
// The colours sit in a ring of 64 cells that rotates one place a cycle; the
// head cell is compared with the current run and the tail takes the new
// colour inside the range. A request takes one full revolution plus a final
// step after acceptance; req_ready is high only between requests.
// When the receiver stalls, the rotation halts until the result is taken.
// cfg_valid/cfg_ready writes used_length, always ready; write it only when idle.
// Reset clears all colours to zero and sets used_length to 64.
`default_nettype none
module range_assign_run_report_top (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire  [rarr_pkg::LEN_W-1:0]    cfg_data,
    input  wire                           req_valid,
    output logic                          req_ready,
    input  wire  [rarr_pkg::POS_W-1:0]    range_start,
    input  wire  [rarr_pkg::END_W-1:0]    range_end,
    input  wire  [rarr_pkg::COLOR_W-1:0]  new_color,
    output logic                          res_valid,
    input  wire                           res_ready,
    output logic [rarr_pkg::POS_W-1:0]    run_start,
    output logic [rarr_pkg::END_W-1:0]    run_end,
    output logic [rarr_pkg::COLOR_W-1:0]  old_color,
    output logic                          last_run,
    output logic                          bad_range
);
    import rarr_pkg::*;

    state_t             state_reg, state_next;
    logic [LEN_W-1:0]   used_length_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [POS_W-1:0]   s_reg;
    logic [END_W-1:0]   e_reg;
    color_t             color_reg;
    logic [POS_W-1:0]   run_s_reg;
    color_t             run_c_reg;

    logic               res_valid_reg;
    logic [POS_W-1:0]   run_start_reg;
    logic [END_W-1:0]   run_end_reg;
    color_t             old_color_reg;
    logic               last_run_reg;
    logic               bad_range_reg;

    logic [LEN_W-1:0]   eff_len;
    logic               req_bad;
    logic               accept;
    logic               slot_free;
    color_t             head;
    color_t             feed;
    logic [CNT_W-1:0]   s_ext;
    logic [CNT_W-1:0]   e_ext;
    logic               at_start;
    logic               in_range;
    logic               at_end;
    logic               emit_mid;
    logic               advance;
    logic               shift;
    logic               load_run;
    logic               load_bad;
    logic               scan_done;

    // Configuration register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_length_reg <= LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            used_length_reg <= cfg_data;
        end
    end

    // Range check against the effective length.
    assign eff_len = (used_length_reg > LEN_W'(POSITIONS)) ? LEN_W'(POSITIONS)
                                                           : used_length_reg;
    assign req_bad = ({1'b0, range_start} >= range_end) || (range_end > eff_len);

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign slot_free = !res_valid_reg || res_ready;

    // Scan step: the head cell holds position cnt_reg.
    assign s_ext     = CNT_W'(s_reg);
    assign e_ext     = CNT_W'(e_reg);
    assign at_start  = (cnt_reg == s_ext);
    assign in_range  = (cnt_reg >= s_ext) && (cnt_reg < e_ext);
    assign at_end    = (cnt_reg == e_ext);
    assign emit_mid  = (cnt_reg > s_ext) && (cnt_reg < e_ext) && (head != run_c_reg);
    assign scan_done = (cnt_reg == CNT_W'(POSITIONS));

    // Output-side controls per state.
    always_comb
    begin
        advance  = 1'b0;
        load_run = 1'b0;
        load_bad = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                advance = 1'b0;
            end
            ST_SCAN:
            begin
                advance  = !((emit_mid || at_end) && !slot_free);
                load_run = (emit_mid || at_end) && slot_free;
            end
            ST_BAD:
            begin
                load_bad = slot_free;
            end
            default:
            begin
                advance = 1'b0;
            end
        endcase
    end

    assign shift = advance && !scan_done;
    assign feed  = in_range ? color_reg : head;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = req_bad ? ST_BAD : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (advance && scan_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_BAD:
            begin
                if (load_bad)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                cnt_reg <= '0;
            end
            else if (advance)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (load_run || load_bad)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Request fields and the run being tracked.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_reg     <= range_start;
            e_reg     <= range_end;
            color_reg <= new_color;
        end
        if (advance && (at_start || emit_mid))
        begin
            run_s_reg <= cnt_reg[POS_W-1:0];
            run_c_reg <= head;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (load_run)
        begin
            run_start_reg <= run_s_reg;
            run_end_reg   <= cnt_reg[END_W-1:0];
            old_color_reg <= run_c_reg;
            last_run_reg  <= at_end;
            bad_range_reg <= 1'b0;
        end
        else if (load_bad)
        begin
            run_start_reg <= '0;
            run_end_reg   <= '0;
            old_color_reg <= '0;
            last_run_reg  <= 1'b1;
            bad_range_reg <= 1'b1;
        end
    end

    // Colour store.
    rarr_ring u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (shift),
        .feed  (feed),
        .head  (head)
    );

    assign res_valid = res_valid_reg;
    assign run_start = run_start_reg;
    assign run_end   = run_end_reg;
    assign old_color = old_color_reg;
    assign last_run  = last_run_reg;
    assign bad_range = bad_range_reg;

endmodule
`default_nettype wire

### src/rarr_cell.sv
`default_nettype none
module rarr_cell (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              shift,
    input  wire rarr_pkg::color_t d,
    output rarr_pkg::color_t q
);
    import rarr_pkg::*;

    color_t color_reg;

    // One stored colour; takes its neighbour's value on every shift.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= '0;
        end
        else if (shift)
        begin
            color_reg <= d;
        end
    end

    assign q = color_reg;

endmodule
`default_nettype wire

### src/rarr_ring.sv
`default_nettype none
module rarr_ring (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              shift,
    input  wire rarr_pkg::color_t feed,
    output rarr_pkg::color_t head
);
    import rarr_pkg::*;

    color_t q [POSITIONS];

    // Each cell hands its colour towards the head; the tail takes the feed,
    // so a full revolution brings every position back to its own cell.
    genvar i;
    generate
        for (i = 0; i < POSITIONS; i++)
        begin : g_cell
            if (i == POSITIONS - 1)
            begin : g_tail
                rarr_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (shift),
                    .d     (feed),
                    .q     (q[i])
                );
            end
            else
            begin : g_body
                rarr_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (shift),
                    .d     (q[i+1]),
                    .q     (q[i])
                );
            end
        end
    endgenerate

    assign head = q[0];

endmodule
`default_nettype wire
